// ===== rtl/core/mebs_pkg.sv =====
// Shared types and constants for the minimum-error boundary seam core.
// No dependencies; mebs_ctrl, mebs_dp and the top core in rtl/core import it.
`default_nettype none
package mebs_pkg;

  localparam int MAX_ROWS_DEF = 1024;
  localparam int MAX_COLS_DEF = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ROWS_W     = 11;
  localparam int COLS_W     = 7;
  localparam int L_W        = 11;
  localparam int AB_W       = 12;
  localparam int QROW_W     = 10;
  localparam int POINT_W    = 10;
  localparam int COST_W     = 36;
  localparam int STATUS_W   = 2;
  localparam int DIFF_W     = 13;
  localparam int MAG_W      = 12;
  localparam int SQ_W       = 24;
  localparam int ERR_W      = 26;

  localparam logic [CFG_IDX_W-1:0] CFG_SEAM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEAM_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 2'd2;

  localparam logic [ROWS_W-1:0] RST_SEAM_ROWS = 11'd1024;
  localparam logic [COLS_W-1:0] RST_SEAM_COLS = 7'd16;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SEAM = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ROW = 2'd2;

  typedef struct packed {
    logic ld_accept;
    logic q_accept;
    logic sq_step;
    logic e_first;
    logic e_add;
    logic ld_write;
    logic trace_init;
    logic trace_issue;
    logic trace_next;
    logic seam_done;
    logic out_load;
  } mebs_cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic seam_end;
    logic row_zero;
    logic out_free;
  } mebs_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/mebs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module mebs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/mebs_ctrl.sv =====
// Sequencer of the seam core: load, seam finish, backtrack and query steps.
// Depends on mebs_pkg for the command and status structs.
`default_nettype none
module mebs_ctrl
  import mebs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_mode,
  output      logic       in_stall,
  input  wire mebs_stat_t stat,
  output      mebs_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LD1, S_LD2, S_LD3, S_LD4, S_LD5,
    S_FIND, S_TR_INIT, S_TR_ISSUE, S_TR_NEXT, S_Q_RD, S_Q_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_QUERY) begin
            cmd.q_accept = 1'b1;
            state_nxt    = S_Q_RD;
          end else begin
            cmd.ld_accept = 1'b1;
            state_nxt     = S_LD1;
          end
        end
      end
      S_LD1: begin
        cmd.sq_step = 1'b1;
        state_nxt   = S_LD2;
      end
      S_LD2: begin
        cmd.sq_step = 1'b1;
        cmd.e_first = 1'b1;
        state_nxt   = S_LD3;
      end
      S_LD3: begin
        cmd.sq_step = 1'b1;
        cmd.e_add   = 1'b1;
        state_nxt   = S_LD4;
      end
      S_LD4: begin
        cmd.e_add = 1'b1;
        state_nxt = S_LD5;
      end
      S_LD5: begin
        cmd.ld_write = 1'b1;
        state_nxt    = stat.seam_end ? S_FIND : S_IDLE;
      end
      S_FIND: begin
        if (!stat.scan_busy) begin
          state_nxt = S_TR_INIT;
        end
      end
      S_TR_INIT: begin
        cmd.trace_init = 1'b1;
        state_nxt      = S_TR_ISSUE;
      end
      S_TR_ISSUE: begin
        cmd.trace_issue = 1'b1;
        if (stat.row_zero) begin
          cmd.seam_done = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_TR_NEXT;
        end
      end
      S_TR_NEXT: begin
        cmd.trace_next = 1'b1;
        state_nxt      = S_TR_ISSUE;
      end
      S_Q_RD: begin
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/mebs_dp.sv =====
// Datapath of the seam core: error squares, neighbor minimum scan, cost and
// direction stores, backtrack, path store and result register.
// Depends on mebs_pkg and mebs_ram.
`default_nettype none
module mebs_dp
  import mebs_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [L_W-1:0]          in_l_first,
  input  wire logic signed [AB_W-1:0]  in_a_first,
  input  wire logic signed [AB_W-1:0]  in_b_first,
  input  wire logic [L_W-1:0]          in_l_second,
  input  wire logic signed [AB_W-1:0]  in_a_second,
  input  wire logic signed [AB_W-1:0]  in_b_second,
  input  wire logic [QROW_W-1:0]       in_query_row,
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      logic [POINT_W-1:0]      out_point_x,
  output      logic [POINT_W-1:0]      out_point_y,
  output      logic [COST_W-1:0]       out_seam_cost,
  output      logic [STATUS_W-1:0]     out_status,
  input  wire mebs_cmd_t               cmd,
  output      mebs_stat_t              stat
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RUW = RW + 1;
  localparam int CUW = CW + 1;

  // Configuration and load position.
  logic [ROWS_W-1:0] cfg_rows_r;
  logic [COLS_W-1:0] cfg_cols_r;
  logic              transpose_r;
  logic [RW-1:0]     load_row_r;
  logic [CW-1:0]     load_col_r;
  logic              seam_ready_r;
  logic [COST_W-1:0] best_cost_r;

  logic [RUW-1:0] rows_used;
  logic [CUW-1:0] cols_used;
  logic [RW-1:0]  rows_m1;
  logic [CW-1:0]  cols_m1;

  always_comb begin
    if (cfg_rows_r == '0) begin
      rows_used = RUW'(1);
    end else if (32'(cfg_rows_r) > 32'(MAX_ROWS)) begin
      rows_used = RUW'(MAX_ROWS);
    end else begin
      rows_used = RUW'(cfg_rows_r);
    end
    if (cfg_cols_r == '0) begin
      cols_used = CUW'(1);
    end else if (32'(cfg_cols_r) > 32'(MAX_COLS)) begin
      cols_used = CUW'(MAX_COLS);
    end else begin
      cols_used = CUW'(cfg_cols_r);
    end
  end

  assign rows_m1 = RW'(rows_used - RUW'(1));
  assign cols_m1 = CW'(cols_used - CUW'(1));

  // Pixel error: three squares through one squarer, accumulated.
  logic signed [DIFF_W-1:0] d0_r, d1_r, d2_r;
  logic [DIFF_W-1:0]        d0_neg;
  logic [MAG_W-1:0]         mag;
  logic [SQ_W-1:0]          prod_r;
  logic [ERR_W-1:0]         e_r;

  assign d0_neg = -d0_r;
  assign mag    = d0_r[DIFF_W-1] ? d0_neg[MAG_W-1:0] : d0_r[MAG_W-1:0];

  // Minimum scan over the cost store (neighbors on load, whole row on finish).
  logic              scan_act_r;
  logic [CW-1:0]     scan_idx_r;
  logic [CW-1:0]     scan_end_r;
  logic              scan_bank_r;
  logic              cmp_vld_r;
  logic              cmp_first_r;
  logic [CW-1:0]     cmp_idx_r;
  logic [COST_W-1:0] min_r;
  logic [CW-1:0]     min_idx_r;
  logic [COST_W-1:0] cost_rd;

  logic [CW-1:0] nb_lo, nb_hi;
  assign nb_lo = (load_col_r == '0) ? '0 : load_col_r - CW'(1);
  assign nb_hi = (load_col_r == cols_m1) ? load_col_r : load_col_r + CW'(1);

  // Cost of the current pixel and its direction code.
  logic [COST_W:0]   cost_sum;
  logic [COST_W-1:0] cost_wr;
  logic [CW:0]       dir_wide;
  logic [1:0]        dir_code;

  assign cost_sum = {(COST_W + 1 - ERR_W)'(0), e_r} + {1'b0, min_r};
  always_comb begin
    if (load_row_r == '0) begin
      cost_wr = COST_W'(e_r);
    end else if (cost_sum[COST_W]) begin
      cost_wr = '1;
    end else begin
      cost_wr = cost_sum[COST_W-1:0];
    end
  end
  assign dir_wide = ({1'b0, min_idx_r} + CUW'(1)) - {1'b0, load_col_r};
  assign dir_code = dir_wide[1:0];

  logic seam_end;
  assign seam_end = (load_col_r == cols_m1) && (load_row_r == rows_m1);

  mebs_ram #(.WIDTH(COST_W), .DEPTH(2 << CW)) u_cost_ram (
    .clk     (clk),
    .wr_en   (cmd.ld_write),
    .wr_addr ({load_row_r[0], load_col_r}),
    .wr_data (cost_wr),
    .rd_addr ({scan_bank_r, scan_idx_r}),
    .rd_data (cost_rd)
  );

  // Backtrack.
  logic [RW-1:0]  tr_row_r;
  logic [CW-1:0]  tr_col_r;
  logic [1:0]     dir_rd;
  logic [CW+1:0]  nj;
  logic [CW+1:0]  nj_m1;
  logic [CW-1:0]  tr_col_nxt;

  assign nj    = {2'b00, tr_col_r} + {CW'(0), dir_rd};
  assign nj_m1 = (nj == '0) ? '0 : nj - (CW + 2)'(1);
  assign tr_col_nxt = ((CW + 2)'(cols_used) <= nj_m1) ? cols_m1 : nj_m1[CW-1:0];

  mebs_ram #(.WIDTH(2), .DEPTH(MAX_ROWS << CW)) u_dir_ram (
    .clk     (clk),
    .wr_en   (cmd.ld_write && (load_row_r != '0)),
    .wr_addr ({load_row_r, load_col_r}),
    .wr_data (dir_code),
    .rd_addr ({tr_row_r, tr_col_r}),
    .rd_data (dir_rd)
  );

  // Path store and query.
  logic [QROW_W-1:0] q_r;
  logic [CW-1:0]     path_rd;

  mebs_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS)) u_path_ram (
    .clk     (clk),
    .wr_en   (cmd.trace_issue),
    .wr_addr (tr_row_r),
    .wr_data (tr_col_r),
    .rd_addr (RW'(q_r)),
    .rd_data (path_rd)
  );

  logic out_valid_r;
  logic [POINT_W-1:0]  px_r, py_r;
  logic [COST_W-1:0]   oc_r;
  logic [STATUS_W-1:0] os_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r   <= RST_SEAM_ROWS;
      cfg_cols_r   <= RST_SEAM_COLS;
      transpose_r  <= 1'b0;
      load_row_r   <= '0;
      load_col_r   <= '0;
      seam_ready_r <= 1'b0;
      best_cost_r  <= '0;
      scan_act_r   <= 1'b0;
      cmp_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cmp_vld_r <= scan_act_r;
      if (scan_act_r && (scan_idx_r == scan_end_r)) begin
        scan_act_r <= 1'b0;
      end
      if (cmd.ld_accept) begin
        scan_act_r <= 1'b1;
      end
      if (cmd.ld_write) begin
        if (load_col_r == cols_m1) begin
          load_col_r <= '0;
          load_row_r <= (load_row_r == rows_m1) ? '0 : load_row_r + RW'(1);
          if (load_row_r == rows_m1) begin
            scan_act_r <= 1'b1;
          end
        end else begin
          load_col_r <= load_col_r + CW'(1);
        end
      end
      if (cmd.trace_init) begin
        best_cost_r <= min_r;
      end
      if (cmd.seam_done) begin
        seam_ready_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEAM_ROWS, CFG_SEAM_COLS: begin
            if (cfg_index == CFG_SEAM_ROWS) begin
              cfg_rows_r <= cfg_wdata;
            end else begin
              cfg_cols_r <= cfg_wdata[COLS_W-1:0];
            end
            load_row_r   <= '0;
            load_col_r   <= '0;
            seam_ready_r <= 1'b0;
          end
          CFG_TRANSPOSE: transpose_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_accept) begin
      d0_r        <= $signed({2'b00, in_l_first}) - $signed({2'b00, in_l_second});
      d1_r        <= {in_a_first[AB_W-1], in_a_first} - {in_a_second[AB_W-1], in_a_second};
      d2_r        <= {in_b_first[AB_W-1], in_b_first} - {in_b_second[AB_W-1], in_b_second};
      scan_idx_r  <= nb_lo;
      scan_end_r  <= nb_hi;
      scan_bank_r <= ~load_row_r[0];
      cmp_first_r <= 1'b1;
    end else if (cmd.ld_write && seam_end) begin
      scan_idx_r  <= '0;
      scan_end_r  <= cols_m1;
      scan_bank_r <= load_row_r[0];
      cmp_first_r <= 1'b1;
    end else if (scan_act_r && (scan_idx_r != scan_end_r)) begin
      scan_idx_r <= scan_idx_r + CW'(1);
    end
    cmp_idx_r <= scan_idx_r;
    if (cmp_vld_r) begin
      cmp_first_r <= 1'b0;
      if (cmp_first_r || (cost_rd < min_r)) begin
        min_r     <= cost_rd;
        min_idx_r <= cmp_idx_r;
      end
    end
    if (cmd.sq_step) begin
      prod_r <= mag * mag;
      d0_r   <= d1_r;
      d1_r   <= d2_r;
    end
    if (cmd.e_first) begin
      e_r <= ERR_W'(prod_r);
    end else if (cmd.e_add) begin
      e_r <= e_r + ERR_W'(prod_r);
    end
    if (cmd.trace_init) begin
      tr_row_r <= rows_m1;
      tr_col_r <= min_idx_r;
    end else if (cmd.trace_next) begin
      tr_row_r <= tr_row_r - RW'(1);
      tr_col_r <= tr_col_nxt;
    end
    if (cmd.q_accept) begin
      q_r <= in_query_row;
    end
    if (cmd.out_load) begin
      px_r <= '0;
      py_r <= '0;
      oc_r <= '0;
      if (!seam_ready_r) begin
        os_r <= STATUS_NO_SEAM;
      end else if (32'(q_r) >= 32'(rows_used)) begin
        os_r <= STATUS_BAD_ROW;
      end else begin
        os_r <= STATUS_OK;
        oc_r <= best_cost_r;
        if (transpose_r) begin
          px_r <= q_r;
          py_r <= POINT_W'(path_rd);
        end else begin
          px_r <= POINT_W'(path_rd);
          py_r <= q_r;
        end
      end
    end
  end

  assign stat.scan_busy = scan_act_r || cmp_vld_r;
  assign stat.seam_end  = seam_end;
  assign stat.row_zero  = (tr_row_r == '0);
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_point_x   = px_r;
  assign out_point_y   = py_r;
  assign out_seam_cost = oc_r;
  assign out_status    = os_r;

endmodule
`default_nettype wire

// ===== rtl/core/min_error_boundary_seam_core.sv =====
// Minimum-error boundary seam core. After a pixel pair (load item) is accepted
// the input side stalls through the load steps S_LD1 to S_LD5, so no new item
// is taken until the pair is through: three squares share one squarer and up
// to three neighbor costs are read one per cycle through the cost store's read
// port. The last pair of a seam adds a bottom-row minimum scan and a backtrack
// that walks the direction store row by row. A query item stalls the input
// side through S_Q_RD and S_Q_OUT, and its result is registered once the output
// is free. Synchronous active-low reset clears control state only.
`default_nettype none
module min_error_boundary_seam_core
  import mebs_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration write port.
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Input items.
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire logic                   in_mode,
  input  wire logic [L_W-1:0]         in_l_first,
  input  wire logic signed [AB_W-1:0] in_a_first,
  input  wire logic signed [AB_W-1:0] in_b_first,
  input  wire logic [L_W-1:0]         in_l_second,
  input  wire logic signed [AB_W-1:0] in_a_second,
  input  wire logic signed [AB_W-1:0] in_b_second,
  input  wire logic [QROW_W-1:0]      in_query_row,
  // Result items.
  output      logic                   out_valid,
  input  wire logic                   out_stall,
  output      logic [POINT_W-1:0]     out_point_x,
  output      logic [POINT_W-1:0]     out_point_y,
  output      logic [COST_W-1:0]      out_seam_cost,
  output      logic [STATUS_W-1:0]    out_status
);

  mebs_cmd_t  cmd;
  mebs_stat_t stat;

  // The controller only sequences; all indexes, stores and arithmetic live in
  // the datapath. The result register lets a new item be taken while a query
  // result is still waiting on the output side.
  mebs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mebs_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_l_first    (in_l_first),
    .in_a_first    (in_a_first),
    .in_b_first    (in_b_first),
    .in_l_second   (in_l_second),
    .in_a_second   (in_a_second),
    .in_b_second   (in_b_second),
    .in_query_row  (in_query_row),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_seam_cost (out_seam_cost),
    .out_status    (out_status),
    .cmd           (cmd),
    .stat          (stat)
  );

  // A load item never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_mode == MODE_LOAD) |=> !$rose(out_valid))
    else $error("result appeared after a load item");

  // A query occupies the block for its store read.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_mode == MODE_QUERY) |=> in_stall)
    else $error("query item did not hold the input side");

  // Results without a seam carry zero fields.
  a_no_seam_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_NO_SEAM) |->
      (out_point_x == '0 && out_point_y == '0 && out_seam_cost == '0))
    else $error("no-seam result carries nonzero fields");

  // Only the controller's result load raises the output valid.
  a_out_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result appeared without a load command");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the minimum-error boundary seam core.
// Depends on mebs_pkg and min_error_boundary_seam_core from rtl/core.
`default_nettype none
module testbench
  import mebs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // The longest quiet stretch is the backtrack of a 1024-row seam plus the
  // idle pause that precedes a register write, so the limit sits well above.
  localparam int DRAIN_CYCLES = 2200;
  localparam int QUIET_LIMIT  = 20000;
  localparam int ITEM_TARGET  = 1950;

  typedef struct {
    logic                   mode;
    logic [L_W-1:0]         l_first;
    logic signed [AB_W-1:0] a_first;
    logic signed [AB_W-1:0] b_first;
    logic [L_W-1:0]         l_second;
    logic signed [AB_W-1:0] a_second;
    logic signed [AB_W-1:0] b_second;
    logic [QROW_W-1:0]      query_row;
  } pixel_item_t;

  typedef struct {
    logic [POINT_W-1:0]  point_x;
    logic [POINT_W-1:0]  point_y;
    logic [COST_W-1:0]   seam_cost;
    logic [STATUS_W-1:0] status;
  } path_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = MODE_LOAD;
  logic [L_W-1:0] in_l_first = '0;
  logic signed [AB_W-1:0] in_a_first = '0;
  logic signed [AB_W-1:0] in_b_first = '0;
  logic [L_W-1:0] in_l_second = '0;
  logic signed [AB_W-1:0] in_a_second = '0;
  logic signed [AB_W-1:0] in_b_second = '0;
  logic [QROW_W-1:0] in_query_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [POINT_W-1:0] out_point_x;
  logic [POINT_W-1:0] out_point_y;
  logic [COST_W-1:0] out_seam_cost;
  logic [STATUS_W-1:0] out_status;

  min_error_boundary_seam_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_l_first(in_l_first), .in_a_first(in_a_first), .in_b_first(in_b_first),
    .in_l_second(in_l_second), .in_a_second(in_a_second),
    .in_b_second(in_b_second), .in_query_row(in_query_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_x(out_point_x), .out_point_y(out_point_y),
    .out_seam_cost(out_seam_cost), .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: registers, cost rows, direction and path stores.
  logic [ROWS_W-1:0] sh_rows = RST_SEAM_ROWS;
  logic [COLS_W-1:0] sh_cols = RST_SEAM_COLS;
  logic              sh_transpose = 1'b0;
  logic [COST_W-1:0] prev_cost [MAX_COLS_DEF];
  logic [COST_W-1:0] cur_cost [MAX_COLS_DEF];
  logic [1:0]        dir_store [MAX_ROWS_DEF*MAX_COLS_DEF];
  logic [5:0]        path_store [MAX_ROWS_DEF];
  int                next_row = 0;
  int                next_col = 0;
  logic [COST_W-1:0] chosen_cost = '0;
  bit                seam_valid = 1'b0;

  pixel_item_t pending_items[$];
  path_point_t expected_points[$];
  pixel_item_t held_item;
  int cyc = 0;
  int quiet = 0;
  int errors = 0;
  int points_checked = 0;
  int seams_done = 0;
  int items_built = 0;

  function automatic int rows_in_use();
    if (sh_rows < 1) return 1;
    if (sh_rows > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return int'(sh_rows);
  endfunction

  function automatic int cols_in_use();
    if (sh_cols < 1) return 1;
    if (sh_cols > MAX_COLS_DEF) return MAX_COLS_DEF;
    return int'(sh_cols);
  endfunction

  // Pick the leftmost minimum of the bottom row and walk the directions up.
  function automatic void trace_seam(int rows, int cols);
    int j;
    int nj;
    j = 0;
    for (int k = 1; k < cols; k++)
      if (cur_cost[k] < cur_cost[j]) j = k;
    chosen_cost = cur_cost[j];
    for (int i = rows - 1; i >= 0; i--) begin
      path_store[i] = j[5:0];
      if (i > 0) begin
        nj = j + int'(dir_store[i*MAX_COLS_DEF + j]);
        j = (nj >= 1) ? nj - 1 : 0;
        if (j >= cols) j = cols - 1;
      end
    end
    seam_valid = 1'b1;
    seams_done++;
  endfunction

  function automatic void accumulate_pixel(pixel_item_t it);
    int rows, cols, r, c, lo, hi, pick;
    longint dl, da, db, sum;
    logic [COST_W-1:0] err;
    rows = rows_in_use();
    cols = cols_in_use();
    r = next_row;
    c = next_col;
    dl = longint'({1'b0, it.l_first}) - longint'({1'b0, it.l_second});
    da = longint'(it.a_first) - longint'(it.a_second);
    db = longint'(it.b_first) - longint'(it.b_second);
    err = COST_W'(dl*dl + da*da + db*db);
    if (r >= rows) r = rows - 1;
    if (c >= cols) c = cols - 1;
    if (r == 0) begin
      cur_cost[c] = err;
    end else begin
      lo = (c == 0) ? 0 : c - 1;
      hi = (c + 1 < cols) ? c + 1 : c;
      pick = lo;
      for (int k = lo + 1; k <= hi; k++)
        if (prev_cost[k] < prev_cost[pick]) pick = k;
      sum = longint'(err) + longint'(prev_cost[pick]);
      cur_cost[c] = (sum > 64'hF_FFFF_FFFF) ? {COST_W{1'b1}} : COST_W'(sum);
      dir_store[r*MAX_COLS_DEF + c] = 2'(pick + 1 - c);
    end
    if (c + 1 >= cols) begin
      for (int k = 0; k < MAX_COLS_DEF; k++) prev_cost[k] = cur_cost[k];
      if (r + 1 >= rows) begin
        trace_seam(rows, cols);
        next_row = 0;
      end else begin
        next_row = r + 1;
      end
      next_col = 0;
    end else begin
      next_row = r;
      next_col = c + 1;
    end
  endfunction

  function automatic path_point_t lookup_point(logic [QROW_W-1:0] q);
    path_point_t p;
    p = '{default: '0};
    if (!seam_valid) begin
      p.status = STATUS_NO_SEAM;
    end else if (int'(q) >= rows_in_use()) begin
      p.status = STATUS_BAD_ROW;
    end else begin
      if (sh_transpose) begin
        p.point_x = q;
        p.point_y = POINT_W'(path_store[q]);
      end else begin
        p.point_x = POINT_W'(path_store[q]);
        p.point_y = q;
      end
      p.seam_cost = chosen_cost;
      p.status = STATUS_OK;
    end
    return p;
  endfunction

  // Driver: holds an item until it is taken, then offers the next one unless
  // this cycle is chosen as an idle gap.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        if (held_item.mode == MODE_LOAD) accumulate_pixel(held_item);
        else expected_points = {expected_points, lookup_point(held_item.query_row)};
      end
      if (pending_items.size() > 0 &&
          ((cyc >= 3000 && cyc < 9000) || $urandom_range(0, 99) >= 34)) begin
        held_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_mode <= held_item.mode;
        in_l_first <= held_item.l_first;
        in_a_first <= held_item.a_first;
        in_b_first <= held_item.b_first;
        in_l_second <= held_item.l_second;
        in_a_second <= held_item.a_second;
        in_b_second <= held_item.b_second;
        in_query_row <= held_item.query_row;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each taken result with the oldest expected point.
  always @(posedge clk) begin
    path_point_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: result with nothing expected: x=%0d y=%0d cost=%0d status=%0d",
                   $realtime, out_point_x, out_point_y, out_seam_cost, out_status);
          errors++;
        end else begin
          want = expected_points.pop_front();
          points_checked++;
          if (out_point_x !== want.point_x) begin
            $display("%0t: point_x expected %0d actual %0d", $realtime,
                     want.point_x, out_point_x);
            errors++;
          end
          if (out_point_y !== want.point_y) begin
            $display("%0t: point_y expected %0d actual %0d", $realtime,
                     want.point_y, out_point_y);
            errors++;
          end
          if (out_seam_cost !== want.seam_cost) begin
            $display("%0t: seam_cost expected %0d actual %0d", $realtime,
                     want.seam_cost, out_seam_cost);
            errors++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime,
                     want.status, out_status);
            errors++;
          end
        end
      end
      out_stall <= !(cyc >= 3000 && cyc < 9000) && $urandom_range(0, 99) < 34;
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic pixel_item_t make_pixel();
    pixel_item_t it;
    it.mode = MODE_LOAD;
    it.query_row = QROW_W'($urandom);
    case ($urandom_range(0, 7))
      0: it.l_first = '0;
      1: it.l_first = 11'd1600;
      2: it.l_first = L_W'($urandom);
      default: it.l_first = L_W'($urandom_range(0, 1600));
    endcase
    case ($urandom_range(0, 7))
      0: it.l_second = '0;
      1: it.l_second = 11'd1600;
      2: it.l_second = L_W'($urandom);
      default: it.l_second = L_W'($urandom_range(0, 1600));
    endcase
    it.a_first = ($urandom_range(0, 5) == 0) ? AB_W'(-2048) : AB_W'($urandom);
    it.b_first = ($urandom_range(0, 5) == 0) ? 12'sd2047 : AB_W'($urandom);
    it.a_second = ($urandom_range(0, 5) == 0) ? 12'sd2047 : AB_W'($urandom);
    it.b_second = ($urandom_range(0, 5) == 0) ? AB_W'(-2048) : AB_W'($urandom);
    // Identical pairs give zero error, which makes cost ties common.
    if ($urandom_range(0, 3) == 0) begin
      it.l_second = it.l_first;
      it.a_second = it.a_first;
      it.b_second = it.b_first;
    end
    return it;
  endfunction

  task automatic queue_query();
    pixel_item_t it;
    int rows;
    rows = rows_in_use();
    it = make_pixel();
    it.mode = MODE_QUERY;
    case ($urandom_range(0, 9))
      0: it.query_row = QROW_W'($urandom);
      1: it.query_row = '1;
      2: it.query_row = QROW_W'(rows);
      3: it.query_row = '0;
      default: it.query_row = QROW_W'($urandom_range(0, rows - 1));
    endcase
    pending_items = {pending_items, it};
    items_built++;
  endtask

  // Loads npix pixel pairs with queries scattered between them.
  task automatic queue_pixels(int npix);
    for (int k = 0; k < npix; k++) begin
      pending_items = {pending_items, make_pixel()};
      items_built++;
      if ($urandom_range(0, 9) < 2) queue_query();
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SEAM_ROWS || idx == CFG_SEAM_COLS) begin
      if (idx == CFG_SEAM_ROWS) sh_rows = val;
      else sh_cols = val[COLS_W-1:0];
      next_row = 0;
      next_col = 0;
      seam_valid = 1'b0;
    end else if (idx == CFG_TRANSPOSE) begin
      sh_transpose = val[0];
    end
  endtask

  // One phase: set the geometry, ask before any seam exists, load whole
  // seams (sometimes ending on a partial one), then queue six queries and four
  // more with the reporting orientation flipped.
  task automatic run_phase(int rows_val, int cols_val, bit tr, int nseams, bit partial);
    write_reg(CFG_SEAM_ROWS, CFG_DATA_W'(rows_val));
    write_reg(CFG_SEAM_COLS, CFG_DATA_W'(cols_val));
    write_reg(CFG_TRANSPOSE, CFG_DATA_W'(tr));
    queue_query();
    for (int s = 0; s < nseams; s++) queue_pixels(rows_in_use() * cols_in_use());
    if (partial) queue_pixels($urandom_range(1, rows_in_use() * cols_in_use()));
    for (int k = 0; k < 6; k++) queue_query();
    wait_idle();
    write_reg(CFG_TRANSPOSE, CFG_DATA_W'(!tr));
    for (int k = 0; k < 4; k++) queue_query();
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Queries straight after reset find no seam.
    queue_query();
    queue_query();
    wait_idle();
    // Directed geometries: the smallest, clamped values and the largest sizes.
    run_phase(3, 4, 1'b0, 2, 1'b0);
    run_phase(1, 1, 1'b1, 2, 1'b0);
    run_phase(0, 5, 1'b0, 2, 1'b0);
    run_phase(2, 64, 1'b1, 2, 1'b1);
    run_phase(2, 127, 1'b0, 1, 1'b0);
    run_phase(2, 0, 1'b0, 1, 1'b0);
    run_phase(2047, 1, 1'b1, 1, 1'b0);
    // Random geometries, mostly small, until enough items have gone in.
    while (items_built < ITEM_TARGET)
      run_phase($urandom_range(1, 12), $urandom_range(1, 9), $urandom_range(0, 1),
                $urandom_range(1, 3), $urandom_range(0, 3) == 0);
    wait_idle();
    $display("Checked %0d path points over %0d completed seams, %0d items sent.",
             points_checked, seams_done, items_built);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
